// ----- sv/tprd_pkg.sv -----
// tprd_pkg: shared types and constants of the tga pixel run decoder
// used by tprd_front, tprd_queue, tprd_back and tga_pixel_run_decoder
`timescale 1ns / 1ps

package tprd_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] HdrRunBit    = 8'h80;
  localparam logic [7:0] HdrCountMask = 8'h7F;
  localparam logic [7:0] OpaqueAlpha  = 8'hFF;

  // configuration register indexes
  localparam logic [1:0] CfgRunLengthMode = 2'd0;
  localparam logic [1:0] CfgAlphaPresent  = 2'd1;
  localparam logic [1:0] CfgPixelTotal    = 2'd2;

  // what the back end does with one pixel byte
  typedef enum logic [2:0] {
    OP_BLUE,
    OP_GREEN,
    OP_RED,
    OP_RED_DONE,
    OP_ALPHA_DONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] count;
    logic       last;
  } cmd_t;

endpackage

// ----- sv/tprd_front.sv -----
// tprd_front: takes stream bytes, tracks pixel phase, packets and image count
// depends on tprd_pkg; emits one command per pixel byte to tprd_queue
`timescale 1ns / 1ps

module tprd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             run_length_mode,
  input  logic             alpha_present,
  input  logic [31:0]      pixel_total,
  output logic             push,
  output tprd_pkg::cmd_t   cmd
);
  import tprd_pkg::*;

  logic [1:0]  byte_phase, byte_phase_next;
  logic        packet_is_run, packet_is_run_next;
  logic [7:0]  packet_pixels_left, packet_pixels_left_next;
  logic [31:0] image_pixels_left, image_pixels_left_next;
  logic        image_started;

  logic [31:0] left_eff;
  logic [31:0] left_after;
  logic [7:0]  count;
  logic        pixel_byte;
  logic        complete;

  assign left_eff = image_started ? image_pixels_left : pixel_total;

  // count of a finished pixel: runs clamp to what is left of the image
  always_comb begin
    count = 8'd1;
    if (run_length_mode && packet_is_run) begin
      if ({24'd0, packet_pixels_left} > left_eff) begin
        count = left_eff[7:0];
      end else begin
        count = packet_pixels_left;
      end
    end
  end

  assign left_after = left_eff - {24'd0, count};

  always_comb begin
    byte_phase_next         = byte_phase;
    packet_is_run_next      = packet_is_run;
    packet_pixels_left_next = packet_pixels_left;
    image_pixels_left_next  = left_eff;
    pixel_byte              = 1'b0;
    complete                = 1'b0;
    cmd.op                  = OP_BLUE;
    cmd.data                = data_byte;
    cmd.count               = count;
    cmd.last                = (left_after == 32'd0);

    if (left_eff != 32'd0) begin
      if (run_length_mode && packet_pixels_left == 8'd0) begin
        // packet header
        packet_is_run_next      = (data_byte & HdrRunBit) != 8'd0;
        packet_pixels_left_next = (data_byte & HdrCountMask) + 8'd1;
        byte_phase_next         = 2'd0;
      end else begin
        pixel_byte = 1'b1;
        case (byte_phase)
          2'd0: begin
            cmd.op          = OP_BLUE;
            byte_phase_next = 2'd1;
          end
          2'd1: begin
            cmd.op          = OP_GREEN;
            byte_phase_next = 2'd2;
          end
          2'd2: begin
            if (alpha_present) begin
              cmd.op          = OP_RED;
              byte_phase_next = 2'd3;
            end else begin
              cmd.op          = OP_RED_DONE;
              byte_phase_next = 2'd0;
              complete        = 1'b1;
            end
          end
          default: begin
            cmd.op          = OP_ALPHA_DONE;
            byte_phase_next = 2'd0;
            complete        = 1'b1;
          end
        endcase
      end
    end

    if (complete) begin
      image_pixels_left_next = left_after;
      if (run_length_mode) begin
        if (packet_is_run) begin
          packet_pixels_left_next = 8'd0;
        end else begin
          packet_pixels_left_next = packet_pixels_left - 8'd1;
        end
      end
    end
  end

  assign push = accept && pixel_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase         <= 2'd0;
      packet_is_run      <= 1'b0;
      packet_pixels_left <= 8'd0;
      image_pixels_left  <= 32'd0;
      image_started      <= 1'b0;
    end else if (accept) begin
      byte_phase         <= byte_phase_next;
      packet_is_run      <= packet_is_run_next;
      packet_pixels_left <= packet_pixels_left_next;
      image_pixels_left  <= image_pixels_left_next;
      image_started      <= 1'b1;
    end
  end

endmodule

// ----- sv/tprd_queue.sv -----
// tprd_queue: short command queue between front and back end
// depends on tprd_pkg for the command type and depth
`timescale 1ns / 1ps

module tprd_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  tprd_pkg::cmd_t                push_cmd,
  input  logic                          pop,
  output logic                          full,
  output logic                          empty,
  output tprd_pkg::cmd_t                head,
  output logic [tprd_pkg::QueueCntW-1:0] level
);
  import tprd_pkg::*;

  cmd_t                 entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;

  assign full  = (level == QueueCntW'(QueueDepth));
  assign empty = (level == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      if (push && !pop) begin
        level <= level + QueueCntW'(1);
      end else if (pop && !push) begin
        level <= level - QueueCntW'(1);
      end
    end
  end

endmodule

// ----- sv/tprd_back.sv -----
// tprd_back: gathers colour bytes from the queue and holds the output pixel
// depends on tprd_pkg; drains tprd_queue into an output register
`timescale 1ns / 1ps

module tprd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  tprd_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic [7:0]     alpha,
  output logic [7:0]     repeat_count,
  output logic           last_pixel
);
  import tprd_pkg::*;

  logic [7:0] blue_hold;
  logic [7:0] green_hold;
  logic [7:0] red_hold;
  logic       slot_free;
  logic       done;

  assign slot_free = !out_valid || !out_stall;
  assign pop       = !q_empty && slot_free;
  assign done      = (head.op == OP_RED_DONE) || (head.op == OP_ALPHA_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      blue_hold  <= 8'd0;
      green_hold <= 8'd0;
      red_hold   <= 8'd0;
    end else if (pop) begin
      case (head.op)
        OP_BLUE:     blue_hold  <= head.data;
        OP_GREEN:    green_hold <= head.data;
        OP_RED:      red_hold   <= head.data;
        OP_RED_DONE: red_hold   <= head.data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && done) begin
      out_valid <= 1'b1;
    end else if (slot_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && done) begin
      green        <= green_hold;
      blue         <= blue_hold;
      repeat_count <= head.count;
      last_pixel   <= head.last;
      if (head.op == OP_RED_DONE) begin
        red   <= head.data;
        alpha <= OpaqueAlpha;
      end else begin
        red   <= red_hold;
        alpha <= head.data;
      end
    end
  end

endmodule

// ----- sv/tga_pixel_run_decoder.sv -----
// tga_pixel_run_decoder: top level of the tga pixel-data decoder
// instantiates tprd_front, tprd_queue and tprd_back; uses tprd_pkg
`timescale 1ns / 1ps

// Decodes the pixel-data bytes of a true-colour TGA image, one byte per transfer
// on the input channel, raw (B,G,R[,A]) or run-length packets. Each finished
// pixel leaves as one output transfer with its colour, alpha (255 on 24-bit
// images), repeat_count (1, or the clamped run length) and last_pixel. Packet
// headers, partial pixel bytes and bytes after the image end give no output.
// The block takes one byte per cycle: the front end updates the phase and
// packet counters and writes a command into a four-entry queue, and the back
// end drains one command per cycle into the output register unless the output
// is stalled, so a byte is accepted every cycle unless the queue is full. The
// pixel count is taken from pixel_total at the first byte after reset; the
// user writes configuration through the cfg channel (ready outside reset)
// while idle, which the block does not enforce. Both the input and the cfg
// channel hold off during reset.

module tga_pixel_run_decoder (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // decoded pixels
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [7:0]  repeat_count,
  output logic        last_pixel,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tprd_pkg::*;

  logic        run_length_mode;
  logic        alpha_present;
  logic [31:0] pixel_total;

  logic                 in_accept;
  logic                 push;
  cmd_t                 push_cmd;
  cmd_t                 head;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;
  logic [QueueCntW-1:0] q_level;

  // configuration registers, written on each cfg transfer
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length_mode <= 1'b0;
      alpha_present   <= 1'b0;
      pixel_total     <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgRunLengthMode: run_length_mode <= cfg_data[0];
        CfgAlphaPresent:  alpha_present   <= cfg_data[0];
        CfgPixelTotal:    pixel_total     <= cfg_data;
        default:          ;
      endcase
    end
  end

  // stall on a full queue or during reset, independent of in_valid
  assign in_stall  = q_full || rst;
  assign in_accept = in_valid && !in_stall;

  tprd_front u_front (
    .clk                (clk),
    .rst                (rst),
    .accept             (in_accept),
    .data_byte          (data_byte),
    .run_length_mode    (run_length_mode),
    .alpha_present      (alpha_present),
    .pixel_total        (pixel_total),
    .push               (push),
    .cmd                (push_cmd)
  );

  tprd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head),
    .level    (q_level)
  );

  tprd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .repeat_count (repeat_count),
    .last_pixel   (last_pixel)
  );

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= QueueCntW'(QueueDepth))
    else $error("command queue level beyond depth");

  // a pixel transfer always carries a repeat count from 1 to 128
  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (repeat_count != 8'd0 && repeat_count <= 8'd128))
    else $error("repeat_count out of range");

  // a full queue never takes a push
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push into full command queue");

endmodule

// ----- dv/tga_pixel_run_decoder_tb.sv -----
// tga_pixel_run_decoder_tb: self-checking testbench of the tga pixel-data decoder
// depends on tprd_pkg and tga_pixel_run_decoder; needs no files or arguments
`timescale 1ns / 1ps

module tga_pixel_run_decoder_tb;
  import tprd_pkg::*;

  // pixels in the one image of the run, loaded at the first byte after reset
  localparam logic [31:0] ImagePixels = 32'd8000;
  // cycles for bytes that give no pixel to clear the front end and queue
  localparam int SettleCycles = 12;
  // run packets are held back so the image cannot end before the last test
  localparam int RunReserve = 600;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  repeat_count;
  logic        last_pixel;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // decoded pixels still owed by the block, oldest first
  pixel_t pending_pixels[$];
  int     mismatches = 0;
  // idling pressure on the input and output sides, in percent per byte and per cycle
  int     gap_pct = 0;
  int     stall_pct = 0;
  int     stall_left = 0;

  // decoder state as seen from the byte stream
  logic        rle_mode;
  logic        alpha_on;
  logic [31:0] total_cfg;
  logic [1:0]  phase;
  logic [7:0]  blue_acc;
  logic [7:0]  green_acc;
  logic [7:0]  red_acc;
  logic        pkt_run;
  logic [7:0]  pkt_left;
  logic [31:0] img_left;
  logic        img_started;

  tga_pixel_run_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .repeat_count (repeat_count),
    .last_pixel   (last_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle bursts: mostly short, now and then a long one
  function automatic int burst_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    else if (r < 95) return $urandom_range(12, 4);
    else return $urandom_range(60, 20);
  endfunction

  // pixel bytes lean towards the extremes now and then
  function automatic logic [7:0] pixel_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    else if (r < 20) return 8'hFF;
    else return 8'($urandom_range(255));
  endfunction

  // one colour byte into the holds; returns 1 once the pixel is whole
  function automatic bit gather_channel(input logic [7:0] d, output logic [7:0] a);
    a = OpaqueAlpha;
    case (phase)
      2'd0: begin
        blue_acc = d;
        phase = 2'd1;
        return 1'b0;
      end
      2'd1: begin
        green_acc = d;
        phase = 2'd2;
        return 1'b0;
      end
      2'd2: begin
        red_acc = d;
        if (alpha_on) begin
          phase = 2'd3;
          return 1'b0;
        end
        phase = 2'd0;
        return 1'b1;
      end
      default: begin
        // a byte at the alpha position always closes the pixel
        phase = 2'd0;
        a = d;
        return 1'b1;
      end
    endcase
  endfunction

  // works out what one accepted byte does, queueing any pixel it completes
  task automatic decode_byte(input logic [7:0] d);
    logic [7:0]  a;
    logic [31:0] cnt;
    pixel_t      px;
    if (!img_started) begin
      img_started = 1'b1;
      img_left = total_cfg;
    end
    if (img_left == 0) return;
    if (rle_mode && pkt_left == 0) begin
      // packet header: kind in the top bit, count in the low seven plus one
      pkt_run = (d & HdrRunBit) != 0;
      pkt_left = (d & HdrCountMask) + 8'd1;
      phase = 2'd0;
      return;
    end
    if (!gather_channel(d, a)) return;
    if (!rle_mode) begin
      cnt = 32'd1;
    end else if (pkt_run) begin
      // run length is clamped to what the image still needs
      cnt = (32'(pkt_left) > img_left) ? img_left : 32'(pkt_left);
      pkt_left = 8'd0;
    end else begin
      cnt = 32'd1;
      pkt_left = pkt_left - 8'd1;
    end
    img_left = img_left - cnt;
    px.red = red_acc;
    px.green = green_acc;
    px.blue = blue_acc;
    px.alpha = a;
    px.repeat_count = cnt[7:0];
    px.last_pixel = (img_left == 0);
    pending_pixels.push_back(px);
  endtask

  // one byte transfer, with an optional gap in front; ends on a falling edge
  task automatic push_byte(input logic [7:0] d);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? burst_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    do @(posedge clk); while (in_stall);
    decode_byte(d);
    @(negedge clk);
  endtask

  task automatic send_pixel();
    repeat (alpha_on ? 4 : 3) push_byte(pixel_value());
  endtask

  // sender stops and waits for every owed pixel, then lets the pipe empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgRunLengthMode: rle_mode = val[0];
      CfgAlphaPresent:  alpha_on = val[0];
      CfgPixelTotal:    total_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // output side stalls at random, in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = burst_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // every output transfer is matched against the oldest owed pixel
  always @(posedge clk) begin
    pixel_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: pixel out with none owed: r %02h g %02h b %02h a %02h n %0d last %0b",
                   $time, red, green, blue, alpha, repeat_count, last_pixel);
        mismatches++;
      end else begin
        e = pending_pixels.pop_front();
        if (red !== e.red || green !== e.green || blue !== e.blue || alpha !== e.alpha ||
            repeat_count !== e.repeat_count || last_pixel !== e.last_pixel) begin
          if (mismatches < 10) begin
            $display("%0t: pixel mismatch", $time);
            $display("  exp r %02h g %02h b %02h a %02h n %0d last %0b",
                     e.red, e.green, e.blue, e.alpha, e.repeat_count, e.last_pixel);
            $display("  got r %02h g %02h b %02h a %02h n %0d last %0b",
                     red, green, blue, alpha, repeat_count, last_pixel);
          end
          mismatches++;
        end
      end
    end
  end

  // image size and modes go in before the first byte starts the image
  task automatic test_registers();
    write_reg(CfgPixelTotal, ImagePixels);
    write_reg(CfgRunLengthMode, 32'd0);
    write_reg(CfgAlphaPresent, 32'd0);
  endtask

  // 24-bit raw pixel, channels at both extremes, alpha forced opaque
  task automatic test_raw_24bit();
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    wait_drained();
  endtask

  // 32-bit raw pixel, alpha taken from the fourth byte
  task automatic test_raw_32bit();
    write_reg(CfgAlphaPresent, 32'd1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);
    wait_drained();
  endtask

  // alpha turned off while a pixel waits for its alpha byte: it still closes it
  task automatic test_alpha_after_switch();
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(8'h56);
    wait_drained();
    write_reg(CfgAlphaPresent, 32'd0);
    push_byte(8'h5A);
    wait_drained();
  endtask

  // pixel_total written mid-image must not move the image end
  task automatic test_late_pixel_total();
    write_reg(CfgPixelTotal, 32'd0);
    write_reg(CfgPixelTotal, 32'hFFFF_FFFF);
  endtask

  // longest run, then a two-pixel literal packet
  task automatic test_rle_packets();
    write_reg(CfgRunLengthMode, 32'd1);
    push_byte(HdrRunBit | HdrCountMask);
    send_pixel();
    push_byte(8'h01);
    send_pixel();
    send_pixel();
    wait_drained();
  endtask

  // raw mode cut into the middle of a literal packet, which then carries on
  task automatic test_mode_switch_in_packet();
    push_byte(8'h01);
    send_pixel();
    wait_drained();
    write_reg(CfgRunLengthMode, 32'd0);
    send_pixel();
    wait_drained();
    write_reg(CfgRunLengthMode, 32'd1);
    send_pixel();
    wait_drained();
  endtask

  // well-formed streams with random content, modes and idling per phase
  task automatic test_random_stream(input int n_items);
    int         per_phase;
    int         cnt;
    int         r;
    logic [7:0] hdr;
    per_phase = n_items / 10;
    for (int p = 0; p < 10; p++) begin
      wait_drained();
      write_reg(CfgRunLengthMode, 32'($urandom_range(1)));
      write_reg(CfgAlphaPresent, 32'($urandom_range(1)));
      case (p % 3)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 15; stall_pct = 20; end
        default: begin gap_pct = $urandom_range(60, 30); stall_pct = $urandom_range(60, 30); end
      endcase
      for (int i = 0; i < per_phase; i++) begin
        if (rle_mode && pkt_left == 0) begin
          r = $urandom_range(99);
          if ($urandom_range(1)) begin
            if (r < 60) cnt = $urandom_range(8, 1);
            else if (r < 90) cnt = $urandom_range(128, 1);
            else cnt = 128;
            // keep the image alive for the end-of-image test
            if (img_left < 32'(RunReserve + cnt)) cnt = 1;
            hdr = HdrRunBit | 8'(cnt - 1);
          end else begin
            if (r < 85) cnt = $urandom_range(8, 1);
            else if (r < 99) cnt = $urandom_range(32, 9);
            else cnt = $urandom_range(128, 33);
            hdr = 8'(cnt - 1);
          end
          push_byte(hdr);
        end else begin
          push_byte(pixel_value());
        end
      end
    end
    gap_pct = 10;
    stall_pct = 10;
  endtask

  // run packets up to the image end, the last one clamped, then trailing bytes
  task automatic test_image_end();
    wait_drained();
    write_reg(CfgRunLengthMode, 32'd1);
    while (pkt_left != 0) push_byte(pixel_value());
    while (img_left >= 129) begin
      push_byte(HdrRunBit | HdrCountMask);
      send_pixel();
    end
    if (img_left == 128) begin
      push_byte(8'h00);
      send_pixel();
    end
    push_byte(HdrRunBit | HdrCountMask);
    send_pixel();
    // past the last pixel nothing more may come out
    repeat (6) push_byte(8'($urandom_range(255)));
    wait_drained();
  endtask

  initial begin
    rle_mode = 1'b0;
    alpha_on = 1'b0;
    total_cfg = 32'd1;
    phase = 2'd0;
    blue_acc = 8'h00;
    green_acc = 8'h00;
    red_acc = 8'h00;
    pkt_run = 1'b0;
    pkt_left = 8'd0;
    img_left = 32'd0;
    img_started = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CfgRunLengthMode;
    cfg_data = 32'd0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_registers();
    test_raw_24bit();
    test_raw_32bit();
    test_alpha_after_switch();
    test_late_pixel_total();
    test_rle_packets();
    test_mode_switch_in_packet();
    test_random_stream(1000);
    test_image_end();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tga_pixel_run_decoder_tb: done, clean");
    end else begin
      $display("tga_pixel_run_decoder_tb: done, errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("tga_pixel_run_decoder_tb: done, errors");
    $finish;
  end

endmodule
